/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; included by ttts_dp.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold on every clock edge out of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be seen on a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/ttts_pkg.sv */
// Types, constants and helpers shared by the timed task table scheduler.
`default_nettype none
package ttts_pkg;

    localparam int TIME_W   = 31;
    localparam int DELAY_W  = 24;
    localparam int STEP_W   = 16;
    localparam int TIDX_W   = 4;
    localparam int REP_W    = 5;

    localparam logic [TIME_W-1:0] TIME_MAX   = 31'h7FFF_FFFF;
    localparam logic [REP_W-1:0]  RESULT_CAP = 5'd16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               op;
        logic [DELAY_W-1:0] delay_ticks;
        logic [DELAY_W-1:0] period_ticks;
        logic               periodic;
    } t_in_word;

    typedef struct packed {
        logic [TIDX_W-1:0] task_index;
        logic              fired;
        logic              accepted;
        logic [TIME_W-1:0] now_time;
        logic              last;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch input word, reset scan state
        logic add;    // commit an add
        logic rd;     // read table entry at scan index
        logic step;   // evaluate entry, advance scan index
        logic fin;    // flush held report, advance time
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_op;
        logic out_free;
        logic scan_done;
        logic chk_stall;
        logic fin_stall;
    } t_sts;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DELAY_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W+1-DELAY_W){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/ttts_ctrl.sv */
// Sequencer for add commits and the tick scan over the task table.
`default_nettype none
module ttts_ctrl
    import ttts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_sts.in_op == OP_TICK) ? S_RD : S_ADD;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_RD: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.chk_stall) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_FIN: begin
                if (!i_sts.fin_stall) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/ttts_dp.sv */
// Task table storage, time counter, scan index and result registers.
`default_nettype none
`include "assert_macros.svh"
module ttts_dp
    import ttts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [STEP_W-1:0] i_cfg_wr_data,
    input  wire t_in_word          i_in_word,
    output t_out_word              o_out_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts
);

    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int EW = CW + TIDX_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

    // table memories: due time, and {periodic, period}
    logic [TIME_W-1:0]  mem_due [TASK_SLOTS];
    logic [DELAY_W:0]   mem_per [TASK_SLOTS];

    t_in_word           r_item;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [STEP_W-1:0]  r_step;
    logic [CW-1:0]      r_count, n_count;
    logic [TASK_SLOTS-1:0] r_active, n_active;
    logic [CW-1:0]      r_idx, n_idx;
    logic [REP_W-1:0]   r_rep_cnt, n_rep_cnt;
    logic               r_hold_valid, n_hold_valid;
    t_out_word          r_hold, n_hold;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;
    logic [TIME_W-1:0]  r_rd_due;
    logic [DELAY_W:0]   r_rd_per;

    logic               w_full, w_out_free, w_hit, w_report;
    logic [IW-1:0]      w_slot, w_add_slot;
    logic [EW-1:0]      w_idx_ext, w_cnt_ext;
    logic               w_due_we, w_per_we;
    logic [IW-1:0]      w_due_addr;
    logic [TIME_W-1:0]  w_due_wdata;

    assign w_full     = (r_count >= SLOTS_C);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_slot     = r_idx[IW-1:0];
    assign w_add_slot = r_count[IW-1:0];
    assign w_idx_ext  = {{TIDX_W{1'b0}}, r_idx};
    assign w_cnt_ext  = {{TIDX_W{1'b0}}, r_count};
    assign w_hit      = r_active[w_slot] && (r_rd_due <= r_time);
    assign w_report   = w_hit && (r_rep_cnt < RESULT_CAP);

    assign o_sts.in_op     = i_in_word.op;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.scan_done = (r_idx >= r_count);
    assign o_sts.chk_stall = w_report && r_hold_valid && !w_out_free;
    assign o_sts.fin_stall = r_hold_valid && !w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // memory write port: add fills the next slot, scan reschedules periodic slots
    always_comb begin
        w_due_we    = 1'b0;
        w_per_we    = 1'b0;
        w_due_addr  = w_slot;
        w_due_wdata = sat_add(r_time, r_rd_per[DELAY_W-1:0]);
        if (i_cmd.add && !w_full) begin
            w_due_we    = 1'b1;
            w_per_we    = 1'b1;
            w_due_addr  = w_add_slot;
            w_due_wdata = sat_add(r_time, r_item.delay_ticks);
        end else if (i_cmd.step && w_hit && r_rd_per[DELAY_W]) begin
            w_due_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_due_we) begin
            mem_due[w_due_addr] <= w_due_wdata;
        end
        if (w_per_we) begin
            mem_per[w_add_slot] <= {r_item.periodic, r_item.period_ticks};
        end
        if (i_cmd.rd) begin
            r_rd_due <= mem_due[w_slot];
            r_rd_per <= mem_per[w_slot];
        end
    end

    always_comb begin
        n_time       = r_time;
        n_count      = r_count;
        n_active     = r_active;
        n_idx        = r_idx;
        n_rep_cnt    = r_rep_cnt;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (i_cmd.load) begin
            n_idx        = '0;
            n_rep_cnt    = '0;
            n_hold_valid = 1'b0;
        end

        if (i_cmd.add) begin
            n_out_valid     = 1'b1;
            n_out.fired     = 1'b0;
            n_out.now_time  = r_time;
            n_out.last      = 1'b1;
            if (w_full) begin
                n_out.task_index = '0;
                n_out.accepted   = 1'b0;
            end else begin
                n_out.task_index     = w_cnt_ext[TIDX_W-1:0];
                n_out.accepted       = 1'b1;
                n_active[w_add_slot] = 1'b1;
                n_count              = r_count + 1'b1;
            end
        end

        if (i_cmd.step) begin
            n_idx = r_idx + 1'b1;
            if (w_hit && !r_rd_per[DELAY_W]) begin
                n_active[w_slot] = 1'b0;
            end
            // a new report pushes the held one out, which is then not the last
            if (w_report) begin
                if (r_hold_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = r_hold;
                end
                n_hold_valid      = 1'b1;
                n_hold.task_index = w_idx_ext[TIDX_W-1:0];
                n_hold.fired      = 1'b1;
                n_hold.accepted   = 1'b0;
                n_hold.now_time   = r_time;
                n_hold.last       = 1'b0;
                n_rep_cnt         = r_rep_cnt + 1'b1;
            end
        end

        if (i_cmd.fin) begin
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out       = r_hold;
                n_out.last  = 1'b1;
            end
            n_hold_valid = 1'b0;
            n_time       = sat_add(r_time, {{(DELAY_W-STEP_W){1'b0}}, r_step});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_step       <= STEP_RESET;
            r_count      <= '0;
            r_active     <= '0;
            r_idx        <= '0;
            r_rep_cnt    <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_time       <= n_time;
            r_count      <= n_count;
            r_active     <= n_active;
            r_idx        <= n_idx;
            r_rep_cnt    <= n_rep_cnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    `ASSERT_NEVER(a_count_max, i_clk, i_rst_n, r_count > SLOTS_C)
    `ASSERT_NEVER(a_rep_cap, i_clk, i_rst_n, r_rep_cnt > RESULT_CAP)
    `ASSERT_AT(a_fin_flush, i_clk, i_rst_n, i_cmd.fin |=> !r_hold_valid)
    `ASSERT_AT(a_add_last, i_clk, i_rst_n, (r_out_valid && !r_out.fired) |-> r_out.last)
    `ASSERT_AT(a_time_mono, i_clk, i_rst_n, 1'b1 |=> (r_time >= $past(r_time)))

endmodule
`default_nettype wire

/* rtl/timed_task_table_scheduler.sv */
// Top level of the timed task table scheduler: controller plus datapath.
//
//  channel   direction  handshake                   word
//  cfg       in         i_cfg_wr_en                 i_cfg_wr_data (tick_step)
//  in        in         i_in_valid / o_in_ready     i_in_word  (t_in_word)
//  out       out        o_out_valid / i_out_ready   o_out_word (t_out_word)
//
// Add: accept, then commit once the output register is free.
// Tick: accept, then for each filled slot a table memory read and a
// check/update step, then an end-of-scan state and the time update.
// Reset is synchronous: time, fill count, active flags clear, tick_step = 100.
// The scan holds on a due slot while a report waits and the output register
// is full; a new word is taken once the previous one is fully handled.
`default_nettype none
module timed_task_table_scheduler
    import ttts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [STEP_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_word          i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_word              o_out_word
);

    t_cmd w_cmd;
    t_sts w_sts;

    ttts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ttts_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .o_out_word    (o_out_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule
`default_nettype wire

/* tb/timed_task_table_scheduler_tb.sv */
// Self-checking testbench for the timed task table scheduler.
module timed_task_table_scheduler_tb;
    import ttts_pkg::*;

    localparam int SLOTS       = 16;
    localparam int SCAN_CYCLES = 2 + 2 * SLOTS + 6;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_WORDS = 60;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [STEP_W-1:0] i_cfg_wr_data = '0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    t_in_word          i_in_word     = '0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    t_out_word         o_out_word;

    bit                rush       = 1'b0;
    bit                steady_in  = 1'b0;
    bit                out_steady = 1'b0;
    logic [STEP_W-1:0] cur_step   = STEP_RESET;

    // Mirror of the task table; predicts the words each accepted input word causes.
    class sched_board;
        logic [TIME_W-1:0]  clock_now;
        logic [STEP_W-1:0]  step;
        int                 filled;
        logic [TIME_W-1:0]  due_at[SLOTS];
        logic [DELAY_W-1:0] interval[SLOTS];
        bit                 repeats[SLOTS];
        bit                 live[SLOTS];
        t_out_word          pending_reports[$];
        int                 mismatches;

        function new();
            clock_now  = '0;
            step       = STEP_RESET;
            filled     = 0;
            mismatches = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function logic [TIME_W-1:0] clamp_sum(logic [TIME_W-1:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {2'b00, a} + {1'b0, b};
            return (s > {2'b00, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
        endfunction

        function void take_input(t_in_word w);
            t_out_word         r;
            int                hits[$];
            logic [TIME_W-1:0] now;
            now        = clock_now;
            r          = '0;
            r.now_time = now;
            if (w.op == OP_ADD) begin
                r.last = 1'b1;
                if (filled < SLOTS) begin
                    due_at[filled]   = clamp_sum(now, {8'b0, w.delay_ticks});
                    interval[filled] = w.period_ticks;
                    repeats[filled]  = w.periodic;
                    live[filled]     = 1'b1;
                    r.task_index     = TIDX_W'(filled);
                    r.accepted       = 1'b1;
                    filled++;
                end
                pending_reports.push_back(r);
            end else begin
                for (int i = 0; i < filled; i++) begin
                    if (live[i] && due_at[i] <= now) begin
                        hits.push_back(i);
                        if (repeats[i])
                            due_at[i] = clamp_sum(now, {8'b0, interval[i]});
                        else
                            live[i] = 1'b0;
                    end
                end
                foreach (hits[k]) begin
                    r.task_index = TIDX_W'(hits[k]);
                    r.fired      = 1'b1;
                    r.last       = (k == hits.size() - 1);
                    pending_reports.push_back(r);
                end
                clock_now = clamp_sum(now, {16'b0, step});
            end
        endfunction

        function void note(string name, longint unsigned want_v, longint unsigned got_v);
            if (want_v != got_v) begin
                $error("%s: expected %0d, actual %0d", name, want_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_report(t_out_word got);
            t_out_word want;
            if (pending_reports.size() == 0) begin
                $error("unexpected word: task_index %0d fired %0d now_time %0d",
                       got.task_index, got.fired, got.now_time);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            note("task_index", want.task_index, got.task_index);
            note("fired", want.fired, got.fired);
            note("accepted", want.accepted, got.accepted);
            note("now_time", want.now_time, got.now_time);
            note("last", want.last, got.last);
        endfunction
    endclass

    sched_board board = new();

    timed_task_table_scheduler #(
        .TASK_SLOTS(SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // delays and periods, half of them scaled to the current step so tasks actually come due
    function automatic logic [DELAY_W-1:0] pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return DELAY_W'($urandom_range(0, 4 * cur_step + 1));
        if (r < 80) return DELAY_W'($urandom_range(0, 16'hFFFF));
        if (r < 95) return DELAY_W'($urandom());
        return $urandom_range(0, 1) ? {DELAY_W{1'b1}} : {DELAY_W{1'b0}};
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w.op           = ($urandom_range(0, 3) == 0) ? OP_ADD : OP_TICK;
        w.delay_ticks  = pick_span();
        w.period_ticks = pick_span();
        w.periodic     = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = (steady_in || rush) ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        board.take_input(w);
    endtask

    task automatic send_add(input logic [DELAY_W-1:0] d, input logic [DELAY_W-1:0] p,
                            input logic per);
        t_in_word w;
        w.op           = OP_ADD;
        w.delay_ticks  = d;
        w.period_ticks = p;
        w.periodic     = per;
        send_word(w);
    endtask

    task automatic send_tick();
        t_in_word w;
        w    = rand_word();
        w.op = OP_TICK;
        send_word(w);
    endtask

    // only with the block idle: all words back and any silent scan finished
    task automatic write_step(input logic [STEP_W-1:0] v);
        i_in_valid <= 1'b0;
        while (board.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SCAN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.step = v;
        cur_step   = v;
    endtask

    // result sink with random back-pressure
    initial begin
        int stall_left;
        int span;
        stall_left = 0;
        span       = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_report(o_out_word);
            span++;
            if (span == 256) begin
                span       = 0;
                out_steady = ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!rush && !out_steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timed_task_table_scheduler_tb: FAIL");
        $finish;
    end

    initial begin
        logic [STEP_W-1:0] plan[6];
        t_in_word          w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: tick reports nothing, time still moves
        send_tick();
        send_add(24'd0, 24'd0, 1'b1);                 // zero period, fires every tick
        send_add(24'hFFFFFF, 24'hFFFFFF, 1'b0);       // far-off one-shot
        send_add(24'd0, 24'h555555, 1'b0);            // one-shot due at once
        send_add(24'd150, 24'd300, 1'b1);
        send_tick();
        send_tick();
        send_tick();
        write_step(16'd0);                            // frozen time
        send_tick();
        send_tick();
        write_step(16'hFFFF);
        send_tick();
        send_tick();
        write_step(16'd1);
        send_add(24'hAAAAAA, 24'd1, 1'b1);
        send_tick();
        send_tick();

        plan[0] = 16'd1;
        plan[1] = 16'hFFFF;
        plan[2] = 16'd0;
        plan[3] = STEP_W'($urandom_range(1, 16'hFFFF));
        plan[4] = STEP_W'($urandom_range(1, 300));
        plan[5] = STEP_RESET;
        foreach (plan[k]) begin
            write_step(plan[k]);
            steady_in = ($urandom_range(0, 2) == 0);
            repeat (PHASE_WORDS) begin
                w = rand_word();
                send_word(w);
            end
        end
        steady_in = 1'b0;

        // back-to-back words with the sink always ready
        write_step(16'hFFFF);
        rush = 1'b1;
        repeat (3) send_tick();
        w    = rand_word();
        w.op = OP_ADD;
        send_word(w);
        send_tick();
        i_in_valid <= 1'b0;

        while (board.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SCAN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("timed_task_table_scheduler_tb: PASS");
        else
            $display("timed_task_table_scheduler_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ttts_pkg.sv
rtl/ttts_ctrl.sv
rtl/ttts_dp.sv
rtl/timed_task_table_scheduler.sv
tb/timed_task_table_scheduler_tb.sv
